FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers clocked on clk; removed under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// checked outside reset
`define E2Q_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked on every edge, reset included
`define E2Q_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define E2Q_ASSERT(lbl, prop, msg)
`define E2Q_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

FILE: sv/e2q_pkg.sv
// ----------------------------------------------------------------------------
// e2q_pkg
// Shared widths, constants, tables and lane types for the Euler to quaternion core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package e2q_pkg;

  localparam int ANGLE_WIDTH   = 32;
  localparam int CORDIC_STAGES = 16;
  localparam int ATAN_COUNT    = 24;
  localparam int NUM_STAGES    = (CORDIC_STAGES > ATAN_COUNT) ? ATAN_COUNT : CORDIC_STAGES;
  localparam int STEP_W        = 5;

  // degree path: angle offset by a multiple of 45, divided by reciprocal multiply
  localparam int VQ_W   = ANGLE_WIDTH + 1;
  localparam int REM_W  = 6;
  localparam logic [REM_W:0] DIV_D = 7'd45;
  localparam logic [63:0] DEG_K   = ((64'd1 << (ANGLE_WIDTH - 1)) + 64'd44) / 64'd45;
  localparam logic [63:0] DEG_OFF = DEG_K * 64'd45;

  // floor(v/45) = (v * ceil(2^DIV_S/45)) >> DIV_S for any v below 2^VQ_W;
  // the reciprocal is split in two halves for narrower multipliers
  localparam int DIV_MW    = VQ_W + 1;
  localparam int DIV_LW    = DIV_MW / 2;
  localparam int DIV_HW    = DIV_MW - DIV_LW;
  localparam int DIV_S     = VQ_W + REM_W;
  localparam int DIV_PW    = VQ_W + DIV_MW;
  localparam int DIV_QW    = DIV_PW - DIV_S;
  localparam int DIV_STEPS = 3;
  localparam logic [63:0] DIV_M = ((64'd1 << DIV_S) + 64'd44) / 64'd45;
  localparam logic [DIV_LW-1:0] DIV_ML = DIV_M[DIV_LW-1:0];
  localparam logic [DIV_HW-1:0] DIV_MH = DIV_M[DIV_MW-1:DIV_LW];

  // length of the valid line, from accepted transaction to done strobe
  localparam int LATENCY = DIV_STEPS + NUM_STAGES + 9;

  localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
  localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;

  typedef logic [44:0][11:0] deg_tab_t;
  typedef logic signed [ATAN_COUNT-1:0][31:0] atan_tab_t;

  // floor(2^n / d), evaluated at elaboration only
  function automatic logic [63:0] pow2_div(input int n, input logic [63:0] d);
    logic [63:0] r;
    logic [63:0] q;
    r = 64'd1;
    q = 64'd0;
    for (int i = 0; i < n; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= d) begin
        r = r - d;
        q = q | 64'd1;
      end
    end
    return q;
  endfunction

  // floor((8192*r + 45) / 90) for each remainder r of the divide by 45
  function automatic deg_tab_t build_deg_tab();
    deg_tab_t t;
    for (int r = 0; r < 45; r++) begin
      t[r] = 12'((8192 * r + 45) / 90);
    end
    return t;
  endfunction

  // round(2^46 / pi): radians to Q0.32 turns of the half angle
  localparam logic [63:0] RAD_K = (pow2_div(107, PI_Q60) + 64'd1) >> 1;
  localparam logic signed [23:0] RAD_KL = {1'b0, RAD_K[22:0]};
  localparam logic signed [22:0] RAD_KH = {1'b0, RAD_K[44:23]};

  localparam deg_tab_t DEG_TAB = build_deg_tab();

  localparam atan_tab_t ATAN_TURNS = {
    32'sh00000051, 32'sh000000A3, 32'sh00000146, 32'sh0000028C,
    32'sh00000518, 32'sh00000A30, 32'sh0000145F, 32'sh000028BE,
    32'sh0000517D, 32'sh0000A2FA, 32'sh000145F3, 32'sh00028BE6,
    32'sh000517CC, 32'sh000A2F98, 32'sh00145F2F, 32'sh0028BE53,
    32'sh00517C55, 32'sh00A2F61E, 32'sh0145D7E1, 32'sh028B0D43,
    32'sh051111D4, 32'sh09FB385B, 32'sh12E4051E, 32'sh20000000
  };

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_t;

  typedef struct packed {
    logic [VQ_W-1:0]               vq;   // dividend in, quotient out
    logic [REM_W-1:0]              rem;
    logic signed [ANGLE_WIDTH-1:0] ang;
  } div_lane_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    quad_t              quad;
  } cordic_lane_t;

endpackage

`default_nettype wire

FILE: sv/e2q_div_cell.sv
// ----------------------------------------------------------------------------
// e2q_div_cell
// Divide by 45 by reciprocal multiply in three registered steps; passes the
// angle along.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module e2q_div_cell import e2q_pkg::*; (
  input  wire logic      clk,
  input  wire div_lane_t din,
  output div_lane_t      dout
);

  logic [VQ_W+DIV_LW-1:0]        p_lo;
  logic [VQ_W+DIV_HW-1:0]        p_hi;
  logic [VQ_W-1:0]               v1;
  logic [VQ_W-1:0]               v2;
  logic signed [ANGLE_WIDTH-1:0] ang1;
  logic signed [ANGLE_WIDTH-1:0] ang2;
  logic [DIV_PW-1:0]             p_sum;
  logic [DIV_QW-1:0]             quo;
  logic [VQ_W-1:0]               quo_ext;
  logic [VQ_W-1:0]               rem_full;

  always_comb begin
    p_sum    = (DIV_PW'(p_hi) << DIV_LW) + DIV_PW'(p_lo);
    quo_ext  = VQ_W'(quo);
    rem_full = v2 - quo_ext * VQ_W'(DIV_D);
  end

  always_ff @(posedge clk) begin
    // step 1: partial products against the two reciprocal halves
    p_lo <= (VQ_W+DIV_LW)'(din.vq) * (VQ_W+DIV_LW)'(DIV_ML);
    p_hi <= (VQ_W+DIV_HW)'(din.vq) * (VQ_W+DIV_HW)'(DIV_MH);
    v1   <= din.vq;
    ang1 <= din.ang;
    // step 2: quotient
    quo  <= p_sum[DIV_PW-1:DIV_S];
    v2   <= v1;
    ang2 <= ang1;
    // step 3: remainder
    dout.vq  <= quo_ext;
    dout.rem <= rem_full[REM_W-1:0];
    dout.ang <= ang2;
  end

endmodule

`default_nettype wire

FILE: sv/e2q_cordic_cell.sv
// ----------------------------------------------------------------------------
// e2q_cordic_cell
// One rotation-mode CORDIC micro-rotation, step index set by the instance.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module e2q_cordic_cell import e2q_pkg::*; (
  input  wire logic              clk,
  input  wire logic [STEP_W-1:0] step,
  input  wire cordic_lane_t      din,
  output cordic_lane_t           dout
);

  logic signed [31:0] dx;
  logic signed [31:0] dy;
  logic signed [31:0] at;
  cordic_lane_t       dout_next;

  always_comb begin
    dx = din.y >>> step;
    dy = din.x >>> step;
    at = ATAN_TURNS[step];
    dout_next.quad = din.quad;
    if (!din.z[31]) begin
      dout_next.x = din.x - dx;
      dout_next.y = din.y + dy;
      dout_next.z = din.z - at;
    end else begin
      dout_next.x = din.x + dx;
      dout_next.y = din.y - dy;
      dout_next.z = din.z + at;
    end
  end

  always_ff @(posedge clk) begin
    dout <= dout_next;
  end

endmodule

`default_nettype wire

FILE: sv/e2q_combine.sv
// ----------------------------------------------------------------------------
// e2q_combine
// Quadrant fold, triple products, sums and Q2.14 rounding with saturation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module e2q_combine import e2q_pkg::*; (
  input  wire logic         clk,
  input  wire cordic_lane_t pitch,
  input  wire cordic_lane_t yaw,
  input  wire cordic_lane_t roll,
  output logic signed [15:0] quat_w,
  output logic signed [15:0] quat_x,
  output logic signed [15:0] quat_y,
  output logic signed [15:0] quat_z
);

  // fold stage
  logic signed [31:0] cp, sp, cy, sy, cr, sr;
  // first products
  logic signed [63:0] m_crcp, m_srsp, m_crsp, m_srcp;
  logic signed [31:0] cy1, sy1;
  // rounded pair products, Q1.30
  logic signed [33:0] r_crcp, r_srsp, r_crsp, r_srcp;
  logic signed [31:0] cy2, sy2;
  // triple products
  logic signed [63:0] t_w1, t_w2, t_x1, t_x2, t_y1, t_y2, t_z1, t_z2;
  // sums
  logic signed [63:0] s_w, s_x, s_y, s_z;

  function automatic logic signed [31:0] fold_cos(input cordic_lane_t l);
    logic signed [31:0] c;
    unique case (l.quad)
      QUAD_0:  c = l.x;
      QUAD_1:  c = -l.y;
      QUAD_2:  c = -l.x;
      default: c = l.y;
    endcase
    return c;
  endfunction

  function automatic logic signed [31:0] fold_sin(input cordic_lane_t l);
    logic signed [31:0] s;
    unique case (l.quad)
      QUAD_0:  s = l.y;
      QUAD_1:  s = l.x;
      QUAD_2:  s = -l.y;
      default: s = -l.x;
    endcase
    return s;
  endfunction

  function automatic logic signed [33:0] round30(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = (p + 64'sd536870912) >>> 30;
    return t[33:0];
  endfunction

  function automatic logic signed [15:0] to_q14(input logic signed [63:0] s);
    logic signed [63:0] t;
    logic signed [17:0] v;
    logic signed [15:0] q;
    t = (s + 64'sh0000_2000_0000_0000) >>> 46;
    v = t[17:0];
    if (v > 18'sd16384) begin
      q = 16'sd16384;
    end else if (v < -18'sd16384) begin
      q = -16'sd16384;
    end else begin
      q = v[15:0];
    end
    return q;
  endfunction

  always_ff @(posedge clk) begin
    cp <= fold_cos(pitch);
    sp <= fold_sin(pitch);
    cy <= fold_cos(yaw);
    sy <= fold_sin(yaw);
    cr <= fold_cos(roll);
    sr <= fold_sin(roll);

    m_crcp <= cr * cp;
    m_srsp <= sr * sp;
    m_crsp <= cr * sp;
    m_srcp <= sr * cp;
    cy1    <= cy;
    sy1    <= sy;

    r_crcp <= round30(m_crcp);
    r_srsp <= round30(m_srsp);
    r_crsp <= round30(m_crsp);
    r_srcp <= round30(m_srcp);
    cy2    <= cy1;
    sy2    <= sy1;

    t_w1 <= r_crcp * cy2;
    t_w2 <= r_srsp * sy2;
    t_x1 <= r_crsp * cy2;
    t_x2 <= r_srcp * sy2;
    t_y1 <= r_crcp * sy2;
    t_y2 <= r_srsp * cy2;
    t_z1 <= r_srcp * cy2;
    t_z2 <= r_crsp * sy2;

    s_w <= t_w1 + t_w2;
    s_x <= t_x1 + t_x2;
    s_y <= t_y1 - t_y2;
    s_z <= t_z1 - t_z2;

    quat_w <= to_q14(s_w);
    quat_x <= to_q14(s_x);
    quat_y <= to_q14(s_y);
    quat_z <= to_q14(s_z);
  end

endmodule

`default_nettype wire

FILE: sv/euler_to_quaternion_core.sv
// ----------------------------------------------------------------------------
// euler_to_quaternion_core
// Pitch, yaw and roll in 16-fraction-bit fixed point to a Q2.14 quaternion.
// ----------------------------------------------------------------------------
// Pipeline from accepted start to done: input capture, the three-step
//   divide-by-45 unit, two phase stages, the CORDIC cell chain and six
//   combine stages.
// Throughput: one transaction per cycle; busy is low except during reset and
//   the cycle after it. The receiver cannot stall; done pulses one cycle.
// Reset: rst (sync, high) clears the pipeline valids and angles_in_degrees and raises busy.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module euler_to_quaternion_core import e2q_pkg::*; (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_wdata,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic signed [ANGLE_WIDTH-1:0] angle_x,
  input  wire logic signed [ANGLE_WIDTH-1:0] angle_y,
  input  wire logic signed [ANGLE_WIDTH-1:0] angle_z,
  output logic                               done,
  output logic signed [15:0]                 quat_w,
  output logic signed [15:0]                 quat_x,
  output logic signed [15:0]                 quat_y,
  output logic signed [15:0]                 quat_z
);

  localparam int NLANE = 3;  // lane 0 pitch, 1 yaw, 2 roll

  logic                 angles_in_degrees;
  logic                 accept;
  logic [LATENCY-1:0]   vld;

  logic signed [ANGLE_WIDTH-1:0] ang [NLANE];

  div_lane_t    div_pipe    [NLANE][2];
  cordic_lane_t cordic_pipe [NLANE][NUM_STAGES+1];

  // phase stage registers
  logic [31:0]                   deg_q [NLANE];
  logic signed [ANGLE_WIDTH+23:0] m_lo [NLANE];
  logic signed [ANGLE_WIDTH+22:0] m_hi [NLANE];
  logic [31:0]                   phase [NLANE];

  assign accept = start && !busy;
  assign done   = vld[LATENCY-1];

  // busy only covers reset and the cycle after it
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      angles_in_degrees <= 1'b0;
    end else if (cfg_we) begin
      angles_in_degrees <= cfg_wdata;
    end
  end

  // valid line tracks each transaction through the data stages
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LATENCY-2:0], accept};
    end
  end

  // input capture; payload loads every cycle, the valid line qualifies it
  always_ff @(posedge clk) begin
    ang[0] <= angle_x;
    ang[1] <= angle_y;
    ang[2] <= angle_z;
  end

  for (genvar l = 0; l < NLANE; l++) begin : g_lane
    // Degree path: v = angle + 45*K is nonnegative, so an unsigned
    // reciprocal divide by 45 gives floor(angle/45) + K and angle mod 45.
    assign div_pipe[l][0].vq  = VQ_W'(ang[l]) + VQ_W'(DEG_OFF);
    assign div_pipe[l][0].rem = '0;
    assign div_pipe[l][0].ang = ang[l];

    e2q_div_cell u_div (
      .clk  (clk),
      .din  (div_pipe[l][0]),
      .dout (div_pipe[l][1])
    );

    // Half-angle phase in Q0.32 turns. Degrees: 4096*(t-K) plus a table
    // term for the remainder. Radians: angle * round(2^46/pi), split in two
    // partial products, rounded and taken from bits 63..32.
    logic [31:0] tq;
    logic [63:0] rad;

    always_comb begin
      tq  = 32'(div_pipe[l][1].vq) - 32'(DEG_K);
      rad = (64'(m_hi[l]) << 23) + 64'(m_lo[l]) + 64'h0000_0000_8000_0000;
    end

    always_ff @(posedge clk) begin
      deg_q[l] <= {tq[19:0], 12'b0} + 32'(DEG_TAB[div_pipe[l][1].rem]);
      m_lo[l]  <= div_pipe[l][1].ang * RAD_KL;
      m_hi[l]  <= div_pipe[l][1].ang * RAD_KH;
      phase[l] <= angles_in_degrees ? deg_q[l] : rad[63:32];
    end

    // CORDIC over the quarter turn below the quadrant bits
    assign cordic_pipe[l][0].x    = CORDIC_GAIN;
    assign cordic_pipe[l][0].y    = '0;
    assign cordic_pipe[l][0].z    = {2'b00, phase[l][29:0]};
    assign cordic_pipe[l][0].quad = quad_t'(phase[l][31:30]);

    for (genvar j = 0; j < NUM_STAGES; j++) begin : g_cordic
      e2q_cordic_cell u_cordic (
        .clk  (clk),
        .step (STEP_W'(j)),
        .din  (cordic_pipe[l][j]),
        .dout (cordic_pipe[l][j+1])
      );
    end
  end

  e2q_combine u_combine (
    .clk    (clk),
    .pitch  (cordic_pipe[0][NUM_STAGES]),
    .yaw    (cordic_pipe[1][NUM_STAGES]),
    .roll   (cordic_pipe[2][NUM_STAGES]),
    .quat_w (quat_w),
    .quat_x (quat_x),
    .quat_y (quat_y),
    .quat_z (quat_z)
  );

  // every done strobe belongs to an earlier accepted transaction
  `E2Q_ASSERT(a_done_matches_accept, done |-> $past(accept, LATENCY), "done without transaction")
  // saturation keeps every component within plus or minus one
  `E2Q_ASSERT(a_quat_range, done |-> (quat_w <= 16'sd16384 && quat_w >= -16'sd16384 && quat_x <= 16'sd16384 && quat_x >= -16'sd16384 && quat_y <= 16'sd16384 && quat_y >= -16'sd16384 && quat_z <= 16'sd16384 && quat_z >= -16'sd16384), "quaternion component out of range")
  // busy stays high only while reset is held or has just been released
  `E2Q_ASSERT(a_busy_clears, !rst |=> !busy, "busy high outside reset")
  // reset empties the pipeline and holds off new transactions
  `E2Q_ASSERT_ALWAYS(a_reset_flush, rst |=> (busy && !done && vld == '0), "pipeline not flushed by reset")

endmodule

`default_nettype wire

FILE: sim/tb_euler_to_quaternion_core.sv
// ----------------------------------------------------------------------------
// tb_euler_to_quaternion_core
// Self-checking bench: queued angle transactions and mode writes drive the
// core, a bit-exact predictor builds the expected quaternion for each accepted
// transaction, and a monitor compares every done strobe against it in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_euler_to_quaternion_core;
  import e2q_pkg::*;

  typedef enum logic {
    JOB_ANGLES = 1'b0,  // one angle transaction
    JOB_MODE   = 1'b1   // write angles_in_degrees while idle
  } job_kind_t;

  typedef struct {
    job_kind_t                     kind;
    logic signed [ANGLE_WIDTH-1:0] ax;
    logic signed [ANGLE_WIDTH-1:0] ay;
    logic signed [ANGLE_WIDTH-1:0] az;
    logic                          deg;
    int                            idle_pct;  // sender gap chance before this job
  } job_t;

  typedef struct {
    logic signed [15:0] w;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } quat_t;

  localparam longint ONE_Q14 = 16384;

  // round(2^46 / pi): radians to Q0.32 turns of the half angle
  function automatic longint unsigned rad_to_turns_k();
    longint unsigned r;
    longint unsigned q;
    r = 1;
    q = 0;
    for (int i = 0; i < 107; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= PI_Q60) begin
        r = r - PI_Q60;
        q = q | 1;
      end
    end
    return (q + 1) >> 1;
  endfunction

  localparam longint unsigned RAD_TURNS = rad_to_turns_k();

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;
  logic start = 1'b0;
  logic signed [ANGLE_WIDTH-1:0] angle_x = '0;
  logic signed [ANGLE_WIDTH-1:0] angle_y = '0;
  logic signed [ANGLE_WIDTH-1:0] angle_z = '0;
  logic busy;
  logic done;
  logic signed [15:0] quat_w;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;

  euler_to_quaternion_core uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .start    (start),
    .busy     (busy),
    .angle_x  (angle_x),
    .angle_y  (angle_y),
    .angle_z  (angle_z),
    .done     (done),
    .quat_w   (quat_w),
    .quat_x   (quat_x),
    .quat_y   (quat_y),
    .quat_z   (quat_z)
  );

  always #10 clk = ~clk;

  job_t  pending_jobs[$];    // stimulus not yet driven
  quat_t expected_quats[$];  // predictions waiting for done
  logic  deg_mode = 1'b0;    // predicted angles_in_degrees
  int    quiet_cycles = 0;   // cycles since the last accepted transaction
  int    mismatches = 0;
  int    n_checked = 0;
  int    n_deg = 0;
  int    n_rad = 0;

  // Half angle as an unsigned Q0.32 fraction of a turn; the wrap is the
  // modulo-2*pi reduction.
  function automatic logic [31:0] half_turn(input logic signed [31:0] a, input logic deg);
    longint av;
    longint num;
    longint q;
    logic [63:0] p;
    av = a;
    if (deg) begin
      // a/65536 degrees halved: a * 8192 / 90, rounded half up, floored
      num = av * 8192 + 45;
      if (num >= 0) q = num / 90;
      else q = -((-num + 89) / 90);
      return q[31:0];
    end else begin
      p = 64'(av) * RAD_TURNS + 64'h8000_0000;
      return p[63:32];
    end
  endfunction

  // Rotation-mode CORDIC over the first quarter turn, then quadrant unfold.
  task automatic cos_sin(input logic [31:0] phase, output longint c, output longint s);
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    quad_t  quad;
    x = longint'(CORDIC_GAIN);
    y = 0;
    z = longint'(phase[29:0]);
    quad = quad_t'(phase[31:30]);
    for (int i = 0; i < NUM_STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - longint'(ATAN_TURNS[i]);
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + longint'(ATAN_TURNS[i]);
      end
    end
    case (quad)
      QUAD_0: begin c = x;  s = y;  end
      QUAD_1: begin c = -y; s = x;  end
      QUAD_2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endtask

  // (a*b rounded to Q1.30) * c, Q.60
  function automatic longint trip(input longint a, input longint b, input longint c);
    return ((a * b + (longint'(1) << 29)) >>> 30) * c;
  endfunction

  function automatic logic signed [15:0] sat_q14(input longint sum);
    longint v;
    v = (sum + (longint'(1) << 45)) >>> 46;
    if (v > ONE_Q14) v = ONE_Q14;
    if (v < -ONE_Q14) v = -ONE_Q14;
    return v[15:0];
  endfunction

  task automatic predict_quat(input logic signed [31:0] px, input logic signed [31:0] py,
                              input logic signed [31:0] pz, input logic deg,
                              output quat_t q);
    longint cp, sp, cy, sy, cr, sr;
    cos_sin(half_turn(px, deg), cp, sp);
    cos_sin(half_turn(py, deg), cy, sy);
    cos_sin(half_turn(pz, deg), cr, sr);
    q.w = sat_q14(trip(cr, cp, cy) + trip(sr, sp, sy));
    q.x = sat_q14(trip(cr, sp, cy) + trip(sr, cp, sy));
    q.y = sat_q14(trip(cr, cp, sy) - trip(sr, sp, cy));
    q.z = sat_q14(trip(sr, cp, cy) - trip(cr, sp, sy));
  endtask

  // Driver: one NBA per signal per edge. A transaction is taken at an edge
  // with start high and busy low; mode writes wait for the pipe to drain.
  always @(posedge clk) begin
    logic  accepted;
    logic  nxt_start;
    logic  nxt_we;
    logic  nxt_wdata;
    quat_t q;
    job_t  j;
    accepted = start && !busy && !rst;
    nxt_start = start && !accepted;
    nxt_we = 1'b0;
    nxt_wdata = cfg_wdata;
    if (accepted) begin
      predict_quat(angle_x, angle_y, angle_z, deg_mode, q);
      expected_quats.push_back(q);
      if (deg_mode) n_deg++;
      else n_rad++;
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (cfg_we && !rst) deg_mode <= cfg_wdata;

    if (!rst && !nxt_start && pending_jobs.size() > 0) begin
      j = pending_jobs[0];
      if (j.kind == JOB_MODE) begin
        // idle: nothing in flight and a full pipe length of quiet
        if (!start && expected_quats.size() == 0 && quiet_cycles > LATENCY + 4 && !cfg_we) begin
          nxt_we = 1'b1;
          nxt_wdata = j.deg;
          void'(pending_jobs.pop_front());
        end
      end else if ($urandom_range(99) >= j.idle_pct) begin
        angle_x <= j.ax;
        angle_y <= j.ay;
        angle_z <= j.az;
        nxt_start = 1'b1;
        void'(pending_jobs.pop_front());
      end
    end
    start <= nxt_start;
    cfg_we <= nxt_we;
    cfg_wdata <= nxt_wdata;
  end

  // Monitor: every done strobe must match the oldest prediction.
  always @(posedge clk) begin
    quat_t e;
    if (!rst && done) begin
      if (expected_quats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected done, got w=%0d x=%0d y=%0d z=%0d",
                   quat_w, quat_x, quat_y, quat_z);
      end else begin
        e = expected_quats.pop_front();
        n_checked++;
        if (quat_w !== e.w || quat_x !== e.x || quat_y !== e.y || quat_z !== e.z) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: quat mismatch exp w=%0d x=%0d y=%0d z=%0d got w=%0d x=%0d y=%0d z=%0d",
                     e.w, e.x, e.y, e.z, quat_w, quat_x, quat_y, quat_z);
        end
      end
    end
  end

  task automatic add_angles(input logic [31:0] ax, input logic [31:0] ay,
                            input logic [31:0] az, input int idle_pct);
    job_t j;
    j.kind = JOB_ANGLES;
    j.ax = ax;
    j.ay = ay;
    j.az = az;
    j.deg = 1'b0;
    j.idle_pct = idle_pct;
    pending_jobs.push_back(j);
  endtask

  task automatic add_mode(input logic deg);
    job_t j;
    j.kind = JOB_MODE;
    j.ax = '0;
    j.ay = '0;
    j.az = '0;
    j.deg = deg;
    j.idle_pct = 0;
    pending_jobs.push_back(j);
  endtask

  // Mostly physically sensible angles (a few turns), some full-range noise.
  function automatic logic [31:0] rand_angle(input logic deg);
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick < 3) return $urandom();
    if (deg) return 32'($signed($urandom_range(0, 1440 * 65536)) - 720 * 65536);
    return 32'($signed($urandom_range(0, 823550)) - 411775);  // about +-1 turn
  endfunction

  // Directed corner set: zero, extremes, sign boundary, quarter and half turns.
  task automatic add_corners(input logic deg);
    logic [31:0] quarter;
    quarter = deg ? 32'(90 * 65536) : 32'd102944;  // pi/2 in radians
    add_angles(32'h0, 32'h0, 32'h0, 0);
    add_angles(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
    add_angles(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
    add_angles(32'hFFFF_FFFF, 32'h1, 32'h8000_0000, 0);
    add_angles(quarter, 32'h0, 32'h0, 0);
    add_angles(32'h0, quarter, 32'h0, 0);
    add_angles(32'h0, 32'h0, quarter, 0);
    add_angles(quarter << 1, -(quarter << 1), quarter << 2, 0);
    add_angles(-quarter, quarter * 3, 32'h7FFF_FFFF, 0);
    add_angles(32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_FFFF, 0);
  endtask

  initial begin
    int pcts[4];
    pcts = '{0, 50, 0, 11};
    // write the register once in reset state too, then alternate modes
    add_mode(1'b0);
    add_corners(1'b0);
    add_mode(1'b1);
    add_corners(1'b1);
    for (int ph = 0; ph < 4; ph++) begin
      add_mode(ph[0]);
      for (int k = 0; k < 220; k++)
        add_angles(rand_angle(ph[0]), rand_angle(ph[0]), rand_angle(ph[0]), pcts[ph]);
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    wait (pending_jobs.size() == 0 && !start && expected_quats.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    $display("Checked %0d quaternions (%0d in degrees, %0d in radians), %0d mismatches",
             n_checked, n_deg, n_rad, mismatches);
    if (mismatches == 0 && expected_quats.size() == 0)
      $display("tb_euler_to_quaternion_core: done, clean");
    else
      $display("tb_euler_to_quaternion_core: done, errors");
    $finish;
  end

  initial begin
    #(20 * 200000);
    $display("ERROR: timeout");
    $display("tb_euler_to_quaternion_core: done, errors");
    $finish;
  end

endmodule

FILE: files.f
+incdir+sv
sv/e2q_pkg.sv
sv/e2q_div_cell.sv
sv/e2q_cordic_cell.sv
sv/e2q_combine.sv
sv/euler_to_quaternion_core.sv
sim/tb_euler_to_quaternion_core.sv
